@@ rtl/core/deq_pkg.sv @@
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 16;

    typedef enum logic [2:0] {
        ACT_PUSH_REAR  = 3'd0,
        ACT_POP_FRONT  = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_LIST_FWD   = 3'd4,
        ACT_LIST_REV   = 3'd5,
        ACT_READ_POS   = 3'd6,
        ACT_DROP_FRONT = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ rtl/core/deq_cmd_if.sv @@
// Command channel: one queue action per beat.
interface deq_cmd_if;
    logic                                valid;
    logic                                ready;
    deq_pkg::action_t                    action;
    logic signed [deq_pkg::VALUE_W-1:0]  value;
    logic        [deq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, action, value, count, input ready);
    modport sink   (input valid, action, value, count, output ready);
endinterface

@@ rtl/core/deq_rsp_if.sv @@
// Response channel: one result per beat.
interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::VALUE_W-1:0]  item_value;
    deq_pkg::status_t                    status;
    logic                                last;

    modport source (output valid, item_value, status, last, input ready);
    modport sink   (input valid, item_value, status, last, output ready);
endinterface

@@ rtl/core/double_ended_queue_unit.sv @@
// Double-ended queue of signed values in a ring RAM, run by a small sequencer.
//
//  channel  dir  payload                      notes
//  cmd      in   action, value, count         taken only while idle
//  rsp      out  item_value, status, last     last marks the final beat of an action
//
// Sequencing: one beat is taken, the next cycle executes it. Pushes into a non-full queue
// and drops finish there; pops, reads and pushes onto a full queue present their result
// the cycle after, pops and reads via one RAM read. Listing returns one element per
// rsp beat, each read after the last beat is taken: one shared slot adder and one RAM read port.
// Reset clears front index, element count and the sequencer; RAM contents are not cleared.
// A stalled rsp holds the result and the sequencer; cmd.ready stays low until done.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Queue control state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;     // list position

    // Latched command
    action_t                    action_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic        [COUNT_W-1:0]  pos_reg;

    // Result held for the response beat
    status_t status_reg, status_next;
    logic    last_reg, last_next;

    // Shared slot unit: (front + offset) mod DEPTH
    logic [IDX_W-1:0] offset;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W-1:0] slot;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic full;
    logic empty;
    logic list_last;
    logic cmd_fire;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = (state_reg == S_OUT);
    assign rsp.status     = status_reg;
    assign rsp.last       = last_reg;
    assign rsp.item_value = (status_reg == ST_OK) ? ram_rdata : '0;

    // Offset into the ring for the current action
    always_comb
    begin
        case (action_reg)
            ACT_PUSH_REAR:  offset = IDX_W'(count_reg);
            ACT_PUSH_FRONT: offset = IDX_W'(DEPTH - 1);
            ACT_POP_FRONT:  offset = IDX_W'(1);
            ACT_POP_REAR:   offset = IDX_W'(count_reg - CNT_W'(1));
            ACT_LIST_FWD:   offset = idx_reg;
            ACT_LIST_REV:   offset = IDX_W'(count_reg - CNT_W'(idx_reg) - CNT_W'(1));
            ACT_READ_POS:   offset = IDX_W'(pos_reg - COUNT_W'(1));
            default:        offset = IDX_W'(pos_reg);
        endcase
    end

    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= (IDX_W + 1)'(DEPTH))
                    ? IDX_W'(slot_sum - (IDX_W + 1)'(DEPTH))
                    : slot_sum[IDX_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = slot;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                last_next   = 1'b1;
                state_next  = S_OUT;
                case (action_reg)
                    ACT_PUSH_REAR, ACT_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_IDLE;
                            if (action_reg == ACT_PUSH_FRONT)
                            begin
                                front_next = slot;
                            end
                        end
                    end

                    ACT_POP_FRONT, ACT_POP_REAR:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            if (action_reg == ACT_POP_FRONT)
                            begin
                                ram_raddr  = front_reg;
                                front_next = slot;
                            end
                        end
                    end

                    ACT_LIST_FWD, ACT_LIST_REV:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            last_next = list_last;
                        end
                    end

                    ACT_READ_POS:
                    begin
                        if ((pos_reg == '0) || (pos_reg > COUNT_W'(count_reg)))
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                        end
                    end

                    default:
                    begin
                        // drop front: clamp to empty when asked for all or more
                        state_next = S_IDLE;
                        if (pos_reg >= COUNT_W'(count_reg))
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        else if (pos_reg != '0)
                        begin
                            front_next = slot;
                            count_next = count_reg - CNT_W'(pos_reg);
                        end
                    end
                endcase
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_EXEC;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    // Command payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            action_reg <= cmd.action;
            value_reg  <= cmd.value;
            pos_reg    <= cmd.count;
        end
    end

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_reg} < (IDX_W + 1)'(DEPTH))
        else $error("front index outside ring");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !full && (state_reg == S_EXEC))
        else $error("ring write while full");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

    a_read_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !empty)
        else $error("ring read with no live element");
endmodule

@@ rtl/core/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ tb/deq_checker.sv @@
// Scoreboard for the deque unit: mirrors the queue contents and checks every rsp beat.
`timescale 1ns / 1ps
module deq_checker (
    input  logic clk,
    input  logic rst_n,
    deq_cmd_if   cmd,
    deq_rsp_if   rsp,
    output int   mismatches,
    output int   results_owed,
    output int   live_count,
    output int   rsp_beats,
    output int   full_drops,
    output int   empty_answers
);
    import deq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        status_t                   status;
        logic                      last;
    } rsp_beat_t;

    rsp_beat_t                 owed_beats[$];
    logic signed [VALUE_W-1:0] ring [DEPTH];
    int                        front_slot;
    int                        live;

    initial
    begin
        mismatches    = 0;
        results_owed  = 0;
        live_count    = 0;
        rsp_beats     = 0;
        full_drops    = 0;
        empty_answers = 0;
        front_slot    = 0;
        live          = 0;
    end

    function automatic int slot_of(input int offset);
        return (front_slot + offset) % DEPTH;
    endfunction

    function automatic void owe(input logic signed [VALUE_W-1:0] v, input status_t s,
                                input logic l);
        rsp_beat_t b;
        b.item_value = v;
        b.status     = s;
        b.last       = l;
        owed_beats.push_back(b);
        if (s == ST_FULL)
            full_drops++;
        if (s == ST_EMPTY)
            empty_answers++;
    endfunction

    // Queue state update and expected rsp beats for one accepted command.
    function automatic void apply_deque_action(input action_t act,
                                               input logic signed [VALUE_W-1:0] v,
                                               input int cnt);
        int off;
        case (act)
            ACT_PUSH_REAR, ACT_PUSH_FRONT:
            begin
                if (live >= DEPTH)
                    owe('0, ST_FULL, 1'b1);
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        front_slot       = slot_of(DEPTH - 1);
                        ring[front_slot] = v;
                    end
                    else
                        ring[slot_of(live)] = v;
                    live++;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR:
            begin
                if (live == 0)
                    owe('0, ST_EMPTY, 1'b1);
                else
                begin
                    if (act == ACT_POP_FRONT)
                    begin
                        owe(ring[front_slot], ST_OK, 1'b1);
                        front_slot = slot_of(1);
                    end
                    else
                        owe(ring[slot_of(live - 1)], ST_OK, 1'b1);
                    live--;
                end
            end
            ACT_LIST_FWD, ACT_LIST_REV:
            begin
                if (live == 0)
                    owe('0, ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < live; i++)
                    begin
                        off = (act == ACT_LIST_FWD) ? i : live - 1 - i;
                        owe(ring[slot_of(off)], ST_OK, i == live - 1);
                    end
            end
            ACT_READ_POS:
            begin
                if (cnt == 0 || cnt > live)
                    owe('0, ST_EMPTY, 1'b1);
                else
                    owe(ring[slot_of(cnt - 1)], ST_OK, 1'b1);
            end
            default:
            begin
                // drop front: a count at or past the fill level wipes the queue
                if (cnt >= live)
                begin
                    front_slot = 0;
                    live       = 0;
                end
                else if (cnt != 0)
                begin
                    front_slot = slot_of(cnt);
                    live       = live - cnt;
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            front_slot = 0;
            live       = 0;
            owed_beats.delete();
        end
        else
        begin
            // rsp beats always belong to earlier commands, so check before predicting
            if (rsp.valid && rsp.ready)
            begin
                rsp_beats++;
                if (owed_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected rsp beat: value %0d status %0d last %0b",
                                 $time, rsp.item_value, rsp.status, rsp.last);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (rsp.item_value !== want.item_value || rsp.status !== want.status
                        || rsp.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] rsp mismatch: expected value %0d status %0d ",
                                      "last %0b, got value %0d status %0d last %0b"},
                                     $time, want.item_value, want.status, want.last,
                                     rsp.item_value, rsp.status, rsp.last);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                apply_deque_action(cmd.action, cmd.value, int'(cmd.count));
        end
        results_owed = owed_beats.size();
        live_count   = live;
    end

endmodule

@@ tb/double_ended_queue_unit_tb.sv @@
// Testbench top for double_ended_queue_unit: stimulus, rsp back-pressure and verdict.
`timescale 1ns / 1ps
module double_ended_queue_unit_tb;
    import deq_pkg::*;

    localparam int     DEPTH        = DEPTH_DEFAULT;
    localparam int     RANDOM_ITEMS = 300;
    localparam int     HOLD_CYCLES  = 300;   // long rsp stall, enough to back up cmd
    localparam int     SETTLE       = 20;    // pushes/drops finish in the execute step after accept, with no rsp beat
    localparam longint WATCHDOG_NS  = 10_000_000;

    logic clk;
    logic rst_n;

    deq_cmd_if cmd_bus ();
    deq_rsp_if rsp_bus ();

    int mismatches;
    int results_owed;
    int live_count;
    int rsp_beats;
    int full_drops;
    int empty_answers;

    // Flags shared between the stimulus and the rsp-side process, plus stimulus state.
    bit idle_on      = 1'b1;   // random gaps/stalls enabled; cleared for the tail
    bit hold_off_req = 1'b0;   // stimulus asks the rsp side for one long stall
    int tx_calm      = 0;      // beats left in a gap-free stretch on cmd
    int items_sent   = 0;
    int action_hits [8];

    double_ended_queue_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    deq_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_bus),
        .rsp           (rsp_bus),
        .mismatches    (mismatches),
        .results_owed  (results_owed),
        .live_count    (live_count),
        .rsp_beats     (rsp_beats),
        .full_drops    (full_drops),
        .empty_answers (empty_answers)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run (every list 64 beats long, every
    // rsp beat behind the longest random stall, every cmd beat behind the longest gap).
    initial
    begin
        #(WATCHDOG_NS);
        $display("watchdog expired, %0d rsp beats still owed", results_owed);
        $display("double_ended_queue_unit_tb NOT OK");
        $finish;
    end

    // Rsp side: random stall bursts, gap-free stretches, and one long hold-off on
    // request. At most one assignment to ready per falling edge.
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left    = 0;
        calm_left     = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (!idle_on)
                rsp_bus.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0)
            begin
                rsp_bus.ready <= 1'b1;
                calm_left--;
            end
            else
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        rsp_bus.ready <= 1'b0;
                        stall_left = $urandom_range(1, 5) - 1;
                    end
                    2:
                    begin
                        rsp_bus.ready <= 1'b1;
                        calm_left = $urandom_range(10, 40);
                    end
                    default: rsp_bus.ready <= 1'b1;
                endcase
        end
    end

    // One cmd beat. Called at a falling edge; returns at the falling edge after the
    // beat was taken, with valid still high so back-to-back beats need no re-raise.
    task automatic send_beat(input action_t act, input logic signed [VALUE_W-1:0] val,
                             input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = 0;
        if (idle_on)
        begin
            if (tx_calm > 0)
                tx_calm--;
            else
                case ($urandom_range(0, 5))
                    0, 1: gap = $urandom_range(1, 5);
                    2: tx_calm = $urandom_range(10, 40);
                    default: ;
                endcase
        end
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= act;
        cmd_bus.value  <= val;
        cmd_bus.count  <= cnt;
        @(posedge clk);
        while (!(cmd_bus.valid && cmd_bus.ready))
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        action_hits[act]++;
    endtask

    // Call with valid already lowered; waits out every owed beat plus the
    // trailing cycles of a push or drop that owes nothing.
    task automatic wait_drained();
        int spin;
        for (spin = 0; spin < 200000 && results_owed != 0; spin++)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random action mix. push_pct steers the fill level: high grows, low shrinks.
    // Reads and drops mostly land inside the live range so the ring wraps and
    // indexed access gets real exercise; the rest probes the edges.
    task automatic random_item(input int push_pct);
        action_t                   act;
        logic signed [VALUE_W-1:0] val;
        logic [COUNT_W-1:0]        cnt;
        int                        pick;
        case ($urandom_range(0, 7))
            0: val = 32'sh7fff_ffff;
            1: val = 32'sh8000_0000;
            2: val = '0;
            3: val = -32'sd1;
            default: val = $urandom;
        endcase
        cnt = COUNT_W'($urandom_range(0, 65535));     // ignored by pushes, pops and lists
        if ($urandom_range(0, 99) < push_pct)
            act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                act = pick[0] ? ACT_POP_FRONT : ACT_POP_REAR;
            else if (pick < 13)
            begin
                act = ACT_READ_POS;
                case ($urandom_range(0, 9))
                    0: cnt = '0;
                    1: cnt = COUNT_W'(live_count + 1);
                    2: cnt = COUNT_W'($urandom_range(0, 65535));
                    default: cnt = (live_count > 0)
                                 ? COUNT_W'($urandom_range(1, live_count)) : COUNT_W'(1);
                endcase
            end
            else if (pick < 16)
                act = pick[0] ? ACT_LIST_FWD : ACT_LIST_REV;
            else
            begin
                act = ACT_DROP_FRONT;
                case ($urandom_range(0, 9))
                    0: cnt = '0;
                    1: cnt = COUNT_W'($urandom_range(0, 65535));
                    2: cnt = COUNT_W'(live_count);
                    default: cnt = COUNT_W'($urandom_range(1, 4));
                endcase
            end
        end
        send_beat(act, val, cnt);
    endtask

    // Push from both ends until full, then hit the full-queue paths: dropped
    // pushes, read of the last and one-past-last position, full-length lists.
    task automatic fill_to_full();
        while (live_count < DEPTH)
            send_beat($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, $urandom,
                      COUNT_W'($urandom_range(0, 65535)));
        send_beat(ACT_PUSH_REAR, $urandom, '0);
        send_beat(ACT_PUSH_FRONT, $urandom, '0);
        send_beat(ACT_READ_POS, '0, COUNT_W'(DEPTH));
        send_beat(ACT_READ_POS, '0, COUNT_W'(DEPTH + 1));
        send_beat(ACT_LIST_REV, '0, '0);
        send_beat(ACT_LIST_FWD, '0, '0);
    endtask

    initial
    begin
        int seg;
        int push_pct;
        int spin;
        rst_n          = 1'b0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.action = ACT_PUSH_REAR;
        cmd_bus.value  = '0;
        cmd_bus.count  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: everything on an empty queue first.
        send_beat(ACT_POP_FRONT, '0, '0);
        send_beat(ACT_POP_REAR, '0, '0);
        send_beat(ACT_LIST_FWD, '0, '0);
        send_beat(ACT_LIST_REV, '0, '0);
        send_beat(ACT_READ_POS, '0, 16'd1);
        send_beat(ACT_DROP_FRONT, '0, 16'd5);
        // Value extremes from both ends, then both listing orders.
        send_beat(ACT_PUSH_REAR, 32'sh7fff_ffff, '0);
        send_beat(ACT_PUSH_FRONT, 32'sh8000_0000, 16'hffff);
        send_beat(ACT_PUSH_REAR, '0, '0);
        send_beat(ACT_PUSH_FRONT, -32'sd1, '0);
        send_beat(ACT_PUSH_REAR, 32'sh5555_aaaa, '0);
        send_beat(ACT_LIST_FWD, '0, '0);
        send_beat(ACT_LIST_REV, '0, '0);
        // Position zero, both ends of the live range, one past, and the max count.
        send_beat(ACT_READ_POS, '0, 16'd0);
        send_beat(ACT_READ_POS, '0, 16'd1);
        send_beat(ACT_READ_POS, '0, 16'd5);
        send_beat(ACT_READ_POS, '0, 16'd6);
        send_beat(ACT_READ_POS, '0, 16'hffff);
        send_beat(ACT_POP_FRONT, '0, '0);
        send_beat(ACT_POP_REAR, '0, '0);
        // Drop nothing, drop one, then drop far past the fill level.
        send_beat(ACT_DROP_FRONT, '0, 16'd0);
        send_beat(ACT_DROP_FRONT, '0, 16'd1);
        send_beat(ACT_LIST_FWD, '0, '0);
        send_beat(ACT_DROP_FRONT, '0, 16'hffff);
        send_beat(ACT_POP_REAR, '0, '0);

        // Random segments cycling grow / balanced / shrink, with two full-queue
        // passes, one long rsp hold-off while cmd keeps offering beats, and one
        // pause on the cmd side until the queue owes nothing.
        seg = 0;
        while (items_sent < RANDOM_ITEMS + 25)
        begin
            if (items_sent > RANDOM_ITEMS - 30)
                idle_on = 1'b0;             // tail runs flat out on both sides
            if (seg == 2 || seg == 8)
                fill_to_full();
            else
            begin
                push_pct = (seg % 3 == 0) ? 75 : (seg % 3 == 1) ? 45 : 15;
                if (seg == 4)
                    hold_off_req = 1'b1;
                repeat (25) random_item(push_pct);
                if (seg == 6)
                begin
                    cmd_bus.valid <= 1'b0;
                    wait_drained();
                end
            end
            seg++;
        end

        cmd_bus.valid <= 1'b0;
        for (spin = 0; spin < 200000 && results_owed != 0; spin++)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("cmd beats %0d: push %0d, pop %0d, read %0d, list %0d, drop %0d",
                 items_sent, action_hits[ACT_PUSH_REAR] + action_hits[ACT_PUSH_FRONT],
                 action_hits[ACT_POP_FRONT] + action_hits[ACT_POP_REAR],
                 action_hits[ACT_READ_POS],
                 action_hits[ACT_LIST_FWD] + action_hits[ACT_LIST_REV],
                 action_hits[ACT_DROP_FRONT]);
        $display("rsp beats %0d, full-queue drops %0d, empty/not-found %0d, mismatches %0d",
                 rsp_beats, full_drops, empty_answers, mismatches);
        if (mismatches == 0 && results_owed == 0)
            $display("double_ended_queue_unit_tb OK");
        else
            $display("double_ended_queue_unit_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/deq_pkg.sv
rtl/core/deq_cmd_if.sv
rtl/core/deq_rsp_if.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_unit.sv
tb/deq_checker.sv
tb/double_ended_queue_unit_tb.sv
